// ----- rtl/core/bis_pkg.sv -----
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types, codes and the control program of the block index search.
// ----------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

  localparam int STEP_W = 4;
  localparam int POS_W  = 7;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {
    FUNC_LOAD_ELEM  = 2'd0,
    FUNC_LOAD_INDEX = 2'd1,
    FUNC_QUERY      = 2'd2,
    FUNC_NONE       = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,
    OP_SEARCH_RD,
    OP_NARROW,
    OP_BLK_RD,
    OP_SET_P,
    OP_ELEM_RD,
    OP_NEXT_P,
    OP_EMIT_HIT,
    OP_EMIT_FAIL
  } op_t;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_QUERY,
    CND_CNT_ZERO,
    CND_KEY_BELOW,
    CND_LO_GE_HI,
    CND_P_GE_STOP,
    CND_ELEM_NE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic no_query;
    logic cnt_zero;
    logic key_below;
    logic lo_ge_hi;
    logic p_ge_stop;
    logic elem_ne;
  } flags_t;

  localparam step_t STEP_IDLE   = 4'd0;
  localparam step_t STEP_LOOP   = 4'd3;
  localparam step_t STEP_BLK    = 4'd5;
  localparam step_t STEP_SCAN   = 4'd7;
  localparam step_t STEP_FAIL   = 4'd10;

  // control program, taken jump goes to target, otherwise to the next step
  function automatic ctrl_word_t bis_rom(input step_t step);
    ctrl_word_t w;
    w = '{op: OP_NOP, cond: CND_ALWAYS, target: STEP_IDLE};
    unique case (step)
      4'd0:    w = '{op: OP_NOP,       cond: CND_NO_QUERY,  target: STEP_IDLE};
      4'd1:    w = '{op: OP_INIT,      cond: CND_CNT_ZERO,  target: STEP_FAIL};
      4'd2:    w = '{op: OP_NOP,       cond: CND_KEY_BELOW, target: STEP_FAIL};
      4'd3:    w = '{op: OP_SEARCH_RD, cond: CND_LO_GE_HI,  target: STEP_BLK};
      4'd4:    w = '{op: OP_NARROW,    cond: CND_ALWAYS,    target: STEP_LOOP};
      4'd5:    w = '{op: OP_BLK_RD,    cond: CND_NEVER,     target: STEP_IDLE};
      4'd6:    w = '{op: OP_SET_P,     cond: CND_NEVER,     target: STEP_IDLE};
      4'd7:    w = '{op: OP_ELEM_RD,   cond: CND_P_GE_STOP, target: STEP_FAIL};
      4'd8:    w = '{op: OP_NEXT_P,    cond: CND_ELEM_NE,   target: STEP_SCAN};
      4'd9:    w = '{op: OP_EMIT_HIT,  cond: CND_ALWAYS,    target: STEP_IDLE};
      4'd10:   w = '{op: OP_EMIT_FAIL, cond: CND_ALWAYS,    target: STEP_IDLE};
      default: w = '{op: OP_NOP,       cond: CND_ALWAYS,    target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bis_seq.sv -----
// ----------------------------------------------------------------------------
// bis_seq
// Step counter and control store; picks the next step from the datapath flags.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_seq (
  input  wire              clk,
  input  wire              rst_n,
  input  bis_pkg::flags_t  flags,
  output bis_pkg::op_t     op,
  output logic             busy
);

  bis_pkg::step_t     step_r;
  bis_pkg::step_t     step_nxt;
  bis_pkg::ctrl_word_t cw;
  logic               take;

  always_comb begin
    cw = bis_pkg::bis_rom(step_r);
    unique case (cw.cond)
      bis_pkg::CND_NEVER:     take = 1'b0;
      bis_pkg::CND_ALWAYS:    take = 1'b1;
      bis_pkg::CND_NO_QUERY:  take = flags.no_query;
      bis_pkg::CND_CNT_ZERO:  take = flags.cnt_zero;
      bis_pkg::CND_KEY_BELOW: take = flags.key_below;
      bis_pkg::CND_LO_GE_HI:  take = flags.lo_ge_hi;
      bis_pkg::CND_P_GE_STOP: take = flags.p_ge_stop;
      bis_pkg::CND_ELEM_NE:   take = flags.elem_ne;
      default:                take = 1'b1;
    endcase
    step_nxt = take ? cw.target : step_r + bis_pkg::step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= bis_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign op   = cw.op;
  assign busy = (step_r != bis_pkg::STEP_IDLE);

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= bis_pkg::STEP_FAIL)
    else $error("step counter outside program");

  a_idle_leave: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == bis_pkg::STEP_IDLE && flags.no_query) |=> step_r == bis_pkg::STEP_IDLE)
    else $error("left idle without a query");

  a_emit_return: assert property (@(posedge clk) disable iff (!rst_n)
    (op == bis_pkg::OP_EMIT_HIT || op == bis_pkg::OP_EMIT_FAIL) |=> !busy)
    else $error("emit step did not return to idle");

endmodule

`default_nettype wire

// ----- rtl/core/block_index_search.sv -----
// ----------------------------------------------------------------------------
// block_index_search
// Index-sequential search: lower-bound binary search over block keys, then
// an in-order scan of the chosen block.
// ----------------------------------------------------------------------------
// Loads (element or index entry) are accepted without leaving idle and busy
// stays low. A query holds busy through the init and key check steps, the
// binary search over the index entries in use, the block read and pointer
// set-up, an in-order scan of the chosen block (each element through the
// registered element memory read) and the emit step; an empty index fails
// at the init step and a key above the last block key at the key check.
// One word per query appears on the out_ ports for one cycle with out_valid;
// the receiver cannot stall it, and the next item may be started while it is
// shown.
`default_nettype none

module block_index_search #(
  parameter int LIST_DEPTH  = 64,
  parameter int INDEX_DEPTH = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire  [1:0]        in_func,
  input  wire  [5:0]        in_slot,
  input  wire  signed [31:0] in_value,
  input  wire  [6:0]        in_block_first,
  input  wire  [6:0]        in_block_last,
  output logic              out_valid,
  output logic              out_found,
  output logic signed [31:0] out_found_value,
  output logic [5:0]        out_found_position,
  input  wire               cfg_we,
  input  wire  [4:0]        cfg_wdata
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int IW = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
  localparam int PW = bis_pkg::POS_W;

  logic [31:0]   elem_mem  [LIST_DEPTH];
  logic [31:0]   key_mem   [INDEX_DEPTH];
  logic [PW-1:0] first_mem [INDEX_DEPTH];
  logic [PW-1:0] last_mem  [INDEX_DEPTH];

  logic [4:0]           block_count_r;
  logic signed [31:0]   key_r;
  logic [IW-1:0]        lo_r, hi_r, mid_r;
  logic [IW-1:0]        lo_nxt, hi_nxt, mid_nxt, key_raddr;
  logic [PW-1:0]        p_r, stop_r, p_nxt, stop_nxt;
  logic signed [31:0]   key_rd_r, elem_rd_r;
  logic [PW-1:0]        first_rd_r, last_rd_r;
  logic                 out_valid_r, out_found_r;
  logic signed [31:0]   out_value_r;
  logic [5:0]           out_pos_r;

  bis_pkg::op_t    op;
  bis_pkg::flags_t flags;
  logic            accept;
  int              cnt_sat;
  logic [IW:0]     mid_sum;

  assign accept = start && !busy;

  bis_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .op    (op),
    .busy  (busy)
  );

  always_comb begin
    flags.no_query  = !(start && in_func == bis_pkg::FUNC_QUERY);
    flags.cnt_zero  = (block_count_r == 5'd0);
    flags.key_below = (key_rd_r < key_r);
    flags.lo_ge_hi  = (lo_r >= hi_r);
    flags.p_ge_stop = (p_r >= stop_r);
    flags.elem_ne   = (elem_rd_r != key_r);
  end

  always_comb begin
    cnt_sat   = (int'(block_count_r) > INDEX_DEPTH) ? INDEX_DEPTH : int'(block_count_r);
    mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
    mid_nxt   = mid_sum[IW:1];
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    p_nxt     = p_r;
    stop_nxt  = stop_r;
    key_raddr = mid_nxt;
    unique case (op)
      bis_pkg::OP_INIT: begin
        lo_nxt    = '0;
        hi_nxt    = IW'(cnt_sat - 1);
        key_raddr = IW'(cnt_sat - 1);
      end
      bis_pkg::OP_NARROW: begin
        if (key_rd_r >= key_r) begin
          hi_nxt = mid_r;
        end else begin
          lo_nxt = mid_r + IW'(1);
        end
      end
      bis_pkg::OP_SET_P: begin
        p_nxt    = (first_rd_r == '0) ? '0 : first_rd_r - PW'(1);
        stop_nxt = (int'(last_rd_r) > LIST_DEPTH) ? PW'(LIST_DEPTH) : last_rd_r;
      end
      bis_pkg::OP_NEXT_P: begin
        if (elem_rd_r != key_r) begin
          p_nxt = p_r + PW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_value;
    end
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    p_r    <= p_nxt;
    stop_r <= stop_nxt;
  end

  // memories
  always_ff @(posedge clk) begin
    if (accept && in_func == bis_pkg::FUNC_LOAD_ELEM && int'(in_slot) < LIST_DEPTH) begin
      elem_mem[AW'(in_slot)] <= in_value;
    end
    elem_rd_r <= elem_mem[AW'(p_r)];
  end

  always_ff @(posedge clk) begin
    if (accept && in_func == bis_pkg::FUNC_LOAD_INDEX && int'(in_slot) < INDEX_DEPTH) begin
      key_mem[IW'(in_slot)]   <= in_value;
      first_mem[IW'(in_slot)] <= in_block_first;
      last_mem[IW'(in_slot)]  <= in_block_last;
    end
    key_rd_r   <= key_mem[key_raddr];
    first_rd_r <= first_mem[lo_r];
    last_rd_r  <= last_mem[lo_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= '0;
    end else if (cfg_we) begin
      block_count_r <= cfg_wdata;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (op == bis_pkg::OP_EMIT_HIT) || (op == bis_pkg::OP_EMIT_FAIL);
    end
    if (op == bis_pkg::OP_EMIT_HIT) begin
      out_found_r <= 1'b1;
      out_value_r <= elem_rd_r;
      out_pos_r   <= p_r[5:0];
    end else if (op == bis_pkg::OP_EMIT_FAIL) begin
      out_found_r <= 1'b0;
      out_value_r <= '0;
      out_pos_r   <= '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_found_value    = out_value_r;
  assign out_found_position = out_pos_r;

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word shown while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_found_value == 0 && out_found_position == 6'd0))
    else $error("failed query carries data");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == bis_pkg::FUNC_QUERY) |=> busy)
    else $error("query accepted without going busy");

  a_hit_match: assert property (@(posedge clk) disable iff (!rst_n)
    (op == bis_pkg::OP_EMIT_HIT) |-> (elem_rd_r == key_r && p_r < stop_r))
    else $error("hit reported without a match");

endmodule

`default_nettype wire

// ----- test/bis_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bis_checker
// Watches the command, result and configuration ports of block_index_search.
// Keeps its own copy of the list, the block index and block_count, works out
// the lookup that each accepted query word should give, and compares every
// result word field by field with the oldest lookup still outstanding.
// ----------------------------------------------------------------------------
module bis_checker #(
  parameter int LIST_DEPTH  = 64,
  parameter int INDEX_DEPTH = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire               busy,
  input  wire  [1:0]        in_func,
  input  wire  [5:0]        in_slot,
  input  wire  signed [31:0] in_value,
  input  wire  [6:0]        in_block_first,
  input  wire  [6:0]        in_block_last,
  input  wire               out_valid,
  input  wire               out_found,
  input  wire  signed [31:0] out_found_value,
  input  wire  [5:0]        out_found_position,
  input  wire               cfg_we,
  input  wire  [4:0]        cfg_wdata,
  output int                fail_count,
  output int                pending,
  output int                results_seen,
  output int                hits_seen
);

  typedef struct packed {
    logic               found;
    logic signed [31:0] value;
    logic [5:0]         position;
  } lookup_t;

  logic signed [31:0] elem_mem  [LIST_DEPTH];
  logic signed [31:0] key_mem   [INDEX_DEPTH];
  logic [6:0]         first_mem [INDEX_DEPTH];
  logic [6:0]         last_mem  [INDEX_DEPTH];
  logic [4:0]         blk_count;
  lookup_t            lookups_due [$];

  // lower-bound search over the block keys, then an in-order scan of the block
  function automatic lookup_t lookup_key(input logic signed [31:0] key);
    lookup_t res;
    int n, lo, hi, mid, p, stop;
    res = '0;
    n = (blk_count > INDEX_DEPTH) ? INDEX_DEPTH : int'(blk_count);
    if (n == 0) return res;
    if (key_mem[n-1] < key) return res;
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (key_mem[mid] >= key) hi = mid;
      else lo = mid + 1;
    end
    p = (first_mem[lo] == 0) ? 0 : int'(first_mem[lo]) - 1;
    stop = (int'(last_mem[lo]) > LIST_DEPTH) ? LIST_DEPTH : int'(last_mem[lo]);
    while (p < stop) begin
      if (elem_mem[p] == key) begin
        res.found    = 1'b1;
        res.value    = elem_mem[p];
        res.position = p[5:0];
        return res;
      end
      p++;
    end
    return res;
  endfunction

  function automatic int field_bad(input string name, input logic signed [31:0] want,
                                   input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    lookup_t want;
    int n_bad;
    n_bad = 0;
    if (!rst_n) begin
      blk_count <= '0;
      lookups_due.delete();
    end else begin
      // a result word may share its cycle with the next query
      if (out_valid !== 1'b0) begin
        if (lookups_due.size() == 0) begin
          $error("result word with no query outstanding");
          n_bad++;
        end else begin
          want = lookups_due.pop_front();
          n_bad += field_bad("found", want.found, out_found);
          n_bad += field_bad("found_value", want.value, out_found_value);
          n_bad += field_bad("found_position", want.position, out_found_position);
          results_seen <= results_seen + 1;
          if (want.found) hits_seen <= hits_seen + 1;
        end
      end
      if (cfg_we) blk_count <= cfg_wdata;
      if (start && !busy) begin
        case (in_func)
          bis_pkg::FUNC_LOAD_ELEM: elem_mem[in_slot] <= in_value;
          bis_pkg::FUNC_LOAD_INDEX: begin
            if (in_slot < INDEX_DEPTH) begin
              key_mem[in_slot]   <= in_value;
              first_mem[in_slot] <= in_block_first;
              last_mem[in_slot]  <= in_block_last;
            end
          end
          bis_pkg::FUNC_QUERY: lookups_due.push_back(lookup_key(in_value));
          default: ;
        endcase
      end
    end
    fail_count <= fail_count + n_bad;
    pending    <= lookups_due.size();
  end

endmodule

// ----- test/tb_block_index_search.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_index_search
// Drives list and index loads, queries and block_count writes into the
// block index search, with random gaps between words. Fills the whole list
// and index first, runs a short directed set of searches, then random phases
// that each rebuild a sorted index over a fresh list and query it.
// ----------------------------------------------------------------------------
module tb_block_index_search;

  localparam int                 ITEMS   = 500;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               start          = 1'b0;
  logic [1:0]         in_func        = bis_pkg::FUNC_LOAD_ELEM;
  logic [5:0]         in_slot        = '0;
  logic signed [31:0] in_value       = '0;
  logic [6:0]         in_block_first = 7'd1;
  logic [6:0]         in_block_last  = 7'd1;
  logic               cfg_we         = 1'b0;
  logic [4:0]         cfg_wdata      = '0;

  wire                busy;
  wire                out_valid;
  wire                out_found;
  wire signed [31:0]  out_found_value;
  wire [5:0]          out_found_position;

  int fail_count, pending, results_seen, hits_seen;

  logic signed [31:0] elem_shadow [64];
  logic signed [31:0] key_shadow  [16];
  int                 list_used  = 64;
  int                 index_used = 16;
  int                 words_sent = 0;
  int                 settings   = 0;
  bit                 burst      = 1'b0;

  block_index_search dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_slot            (in_slot),
    .in_value           (in_value),
    .in_block_first     (in_block_first),
    .in_block_last      (in_block_last),
    .out_valid          (out_valid),
    .out_found          (out_found),
    .out_found_value    (out_found_value),
    .out_found_position (out_found_position),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  bis_checker chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_slot            (in_slot),
    .in_value           (in_value),
    .in_block_first     (in_block_first),
    .in_block_last      (in_block_last),
    .out_valid          (out_valid),
    .out_found          (out_found),
    .out_found_value    (out_found_value),
    .out_found_position (out_found_position),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (fail_count),
    .pending            (pending),
    .results_seen       (results_seen),
    .hits_seen          (hits_seen)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // start stays high after acceptance until the next word or a gap replaces it
  task automatic send_word(input bis_pkg::func_t f, input logic [5:0] s,
                           input logic signed [31:0] v,
                           input logic [6:0] bf, input logic [6:0] bl);
    int gap, r;
    r = $urandom_range(0, 99);
    gap = burst ? 0 : (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_func        <= f;
    in_slot        <= s;
    in_value       <= v;
    in_block_first <= bf;
    in_block_last  <= bl;
    if (f == bis_pkg::FUNC_LOAD_ELEM) elem_shadow[s] = v;
    if (f == bis_pkg::FUNC_LOAD_INDEX && s < 16) key_shadow[s] = v;
    if (f == bis_pkg::FUNC_QUERY || f == bis_pkg::FUNC_LOAD_ELEM ||
        (f == bis_pkg::FUNC_LOAD_INDEX && s < 16))
      words_sent++;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_block_count(input logic [4:0] cnt);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_wdata <= cnt;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  // ascending value bands per block, block key at the top of its band
  task automatic rebuild_index(input int n);
    int stride, lo_pos, hi_pos, end_pos;
    logic signed [31:0] base, key;
    list_used = ($urandom_range(0, 7) == 0) ? 64 :
                (3 * n > 64) ? $urandom_range(n, 64) : $urandom_range(n, 3 * n);
    stride = $urandom_range(1, 5000);
    base = int'($urandom_range(0, 20_000_000)) - 10_000_000;
    for (int b = 0; b < n; b++) begin
      lo_pos = b * list_used / n;
      hi_pos = (b + 1) * list_used / n;
      for (int p = lo_pos; p < hi_pos; p++)
        send_word(bis_pkg::FUNC_LOAD_ELEM, p,
                  base + b * stride + $urandom_range(0, stride - 1), $urandom, $urandom);
      key = base + b * stride + stride - 1;
      if (b > 0 && $urandom_range(0, 11) == 0) key = key_shadow[b-1];
      end_pos = ($urandom_range(0, 15) == 0) ? lo_pos : hi_pos;
      send_word(bis_pkg::FUNC_LOAD_INDEX, b, key,
                (lo_pos == 0 && $urandom_range(0, 3) == 0) ? 0 : lo_pos + 1, end_pos);
    end
    index_used = n;
  endtask

  initial begin : stim
    int n, q, r, sel, cnt;
    logic signed [31:0] v;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // every list and index word is written before any search can read it
    burst = 1'b1;
    for (int p = 0; p < 64; p++)
      send_word(bis_pkg::FUNC_LOAD_ELEM, p,
                (p == 0) ? KEY_MIN : (p == 63) ? KEY_MAX : 10 * p, 1, 1);
    for (int b = 0; b < 16; b++)
      send_word(bis_pkg::FUNC_LOAD_INDEX, b, (b == 15) ? KEY_MAX : 40 * b + 30,
                4 * b + 1, 4 * b + 4);

    burst = 1'b0;
    send_word(bis_pkg::FUNC_QUERY, 0, 50, 1, 1);
    set_block_count(16);
    send_word(bis_pkg::FUNC_QUERY, 0, KEY_MIN, 1, 1);
    send_word(bis_pkg::FUNC_QUERY, 0, KEY_MAX, 1, 1);
    send_word(bis_pkg::FUNC_QUERY, 0, 50, 1, 1);
    send_word(bis_pkg::FUNC_QUERY, 0, 55, 1, 1);
    set_block_count(4);
    send_word(bis_pkg::FUNC_QUERY, 0, 1000, 1, 1);
    send_word(bis_pkg::FUNC_QUERY, 0, 150, 1, 1);
    set_block_count(31);
    send_word(bis_pkg::FUNC_QUERY, 0, 590, 1, 1);
    send_word(bis_pkg::FUNC_NONE, 0, 50, 1, 1);
    send_word(bis_pkg::FUNC_LOAD_INDEX, 40, KEY_MIN, 1, 64);
    send_word(bis_pkg::FUNC_LOAD_INDEX, 0, 30, 0, 4);
    send_word(bis_pkg::FUNC_QUERY, 0, 20, 1, 1);
    send_word(bis_pkg::FUNC_LOAD_INDEX, 1, 70, 8, 3);
    send_word(bis_pkg::FUNC_QUERY, 0, 50, 1, 1);
    send_word(bis_pkg::FUNC_LOAD_INDEX, 15, KEY_MAX, 61, 127);
    send_word(bis_pkg::FUNC_QUERY, 0, KEY_MAX, 1, 1);
    send_word(bis_pkg::FUNC_LOAD_INDEX, 14, 590, 100, 127);
    send_word(bis_pkg::FUNC_QUERY, 0, 570, 1, 1);
    send_word(bis_pkg::FUNC_LOAD_INDEX, 3, 110, 13, 16);
    send_word(bis_pkg::FUNC_QUERY, 0, 110, 1, 1);
    send_word(bis_pkg::FUNC_LOAD_ELEM, 33, -1, 1, 1);
    send_word(bis_pkg::FUNC_QUERY, 0, -1, 1, 1);

    while (words_sent < ITEMS) begin
      burst = ($urandom_range(0, 4) == 0);
      n = $urandom_range(1, 16);
      rebuild_index(n);
      r = $urandom_range(0, 9);
      cnt = (r == 0) ? 0 : (r == 1) ? $urandom_range(17, 31) : (r == 2) ? 16 :
            (r == 3) ? $urandom_range(1, n) : n;
      set_block_count(cnt);
      if (cnt != 0) index_used = (cnt > 16) ? 16 : cnt;
      q = $urandom_range(15, 40);
      repeat (q) begin
        sel = $urandom_range(0, 19);
        if (sel < 11) begin
          send_word(bis_pkg::FUNC_QUERY, $urandom,
                    elem_shadow[$urandom_range(0, list_used - 1)], $urandom, $urandom);
        end else if (sel < 14) begin
          send_word(bis_pkg::FUNC_QUERY, $urandom,
                    key_shadow[$urandom_range(0, index_used - 1)], $urandom, $urandom);
        end else if (sel == 14) begin
          v = key_shadow[index_used - 1];
          if (v != KEY_MAX) v = v + 1;
          send_word(bis_pkg::FUNC_QUERY, $urandom, v, $urandom, $urandom);
        end else if (sel < 17) begin
          send_word(bis_pkg::FUNC_QUERY, $urandom, $urandom, $urandom, $urandom);
        end else if (sel == 17) begin
          send_word(bis_pkg::FUNC_NONE, $urandom, $urandom, $urandom, $urandom);
        end else if (sel == 18) begin
          send_word(bis_pkg::FUNC_LOAD_INDEX, $urandom_range(16, 63), $urandom,
                    $urandom_range(1, 64), $urandom_range(1, 64));
        end else begin
          send_word(bis_pkg::FUNC_LOAD_ELEM, $urandom, $urandom, $urandom, $urandom);
        end
      end
    end

    quiesce();
    repeat (20) @(posedge clk);
    $display("Sent %0d load and query words across %0d block_count settings",
             words_sent, settings);
    $display("Checked %0d search results, %0d of them hits", results_seen, hits_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/bis_pkg.sv
rtl/core/bis_seq.sv
rtl/core/block_index_search.sv
test/bis_checker.sv
test/tb_block_index_search.sv
